// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Operation codes, sequencer states and cell helpers.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int OP_W     = 3;
  localparam int CODE_W   = 8;
  localparam int COLF_W   = 7;
  localparam int ROWF_W   = 5;
  localparam int CELL_W   = 16;
  localparam int INDEX_W  = 11;
  localparam int COLOUR_W = 4;

  localparam logic [OP_W-1:0] OP_PUT_CHAR = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE_AT = 3'd1;
  localparam logic [OP_W-1:0] OP_READ     = 3'd2;
  localparam logic [OP_W-1:0] OP_SCROLL   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  localparam logic [0:0] REG_FORE = 1'b0;
  localparam logic [0:0] REG_BACK = 1'b1;

  localparam logic [CODE_W-1:0]   NEWLINE_CODE = 8'd10;
  localparam logic [CODE_W-1:0]   SPACE_CODE   = 8'd32;
  localparam logic [CODE_W-1:0]   BLANK_CODE   = 8'd0;
  localparam logic [CELL_W-1:0]   RESET_CELL   = 16'h0F00;
  localparam logic [COLOUR_W-1:0] FORE_RESET   = 4'd15;
  localparam logic [COLOUR_W-1:0] BACK_RESET   = 4'd0;

  typedef enum logic [2:0] {
    ST_INIT,        // clearing pass after reset
    ST_IDLE,
    ST_SCROLL,      // copy row r+1 into row r
    ST_SCROLL_LAST, // last copy write
    ST_FILL,        // fill a run of cells with one value
    ST_READ,        // capture read data
    ST_FINISH       // load result register
  } tcw_state_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [CODE_W-1:0] code,
                                                  input logic [COLOUR_W-1:0] fore,
                                                  input logic [COLOUR_W-1:0] back);
    make_cell = {back, fore, code};
  endfunction

endpackage

// ===== sv/tcw_screen_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_screen_ram: screen cell store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
  parameter int DEPTH = 2000,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [tcw_pkg::CELL_W-1:0] wdata,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_core: text-mode console engine
// Screen store of COLUMNS x ROWS cells with put, positioned write, read,
// scroll and clear requests.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_ready is high only while the sequencer
// is idle. Every cell access goes through the single screen RAM port pair,
// and that port pair sets the timing. Put char (no scroll) and write at
// position write their cell on acceptance and load the result register in
// ST_FINISH. Read cell issues its read on acceptance, captures the data in
// ST_READ and goes to ST_FINISH (directly when the position is off screen).
// Scroll, and a put char that runs off the bottom of the screen, make one
// copy per cycle through the RAM (read row below, write row above, reads one
// cell ahead of writes), then fill the freed bottom row. Clear is a fill
// sweep. After reset a clearing pass writes 0x0F00 into all COLUMNS*ROWS
// cells, one per cycle, before the first request is taken; colour writes on
// the configuration port are taken throughout. A finished result waits in an
// output register, so the next request may be taken while it is pending; that
// request then holds in its last cycle until the output register is free.
// The write position is kept as row, column and linear index, so a newline
// needs no division. write_index and cursor_pos are the low 11 bits.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write_en,
  input  logic [0:0]                     cfg_index,
  input  logic [tcw_pkg::COLOUR_W-1:0]   cfg_data,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tcw_pkg::OP_W-1:0]       operation,
  input  logic [tcw_pkg::CODE_W-1:0]     char_code,
  input  logic [tcw_pkg::COLF_W-1:0]     column,
  input  logic [tcw_pkg::ROWF_W-1:0]     row,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tcw_pkg::CELL_W-1:0]     cell_value,
  output logic [tcw_pkg::INDEX_W-1:0]    write_index,
  output logic [tcw_pkg::INDEX_W-1:0]    cursor_pos
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);

  // ---- state -------------------------------------------------------------
  tcw_pkg::tcw_state_t state, state_next;

  logic [tcw_pkg::COLOUR_W-1:0] fore_colour, back_colour;

  // write position: linear index plus row and column
  logic [ADDR_W-1:0] wp_lin, wp_lin_next;
  logic [ROW_W-1:0]  wp_row, wp_row_next;
  logic [COL_W-1:0]  wp_col, wp_col_next;

  logic [tcw_pkg::INDEX_W-1:0] cursor_loc, cursor_loc_next;

  // sweep unit: source and destination counters, one read in flight
  logic [ADDR_W-1:0]          src_cnt, src_cnt_next;
  logic [ADDR_W-1:0]          dst_cnt, dst_cnt_next;
  logic                       rd_pend, rd_pend_next;
  logic [tcw_pkg::CELL_W-1:0] fill_cell, fill_cell_next;

  logic [tcw_pkg::CELL_W-1:0] cell_res, cell_res_next;

  // result register
  logic                        res_valid, res_valid_next;
  logic [tcw_pkg::CELL_W-1:0]  res_cell, res_cell_next;
  logic [tcw_pkg::INDEX_W-1:0] res_index, res_index_next;
  logic [tcw_pkg::INDEX_W-1:0] res_cursor, res_cursor_next;

  // RAM ports
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  // ---- request decode ----------------------------------------------------
  logic              accept;
  logic              in_range;
  logic [ADDR_W-1:0] pos_addr;
  logic              res_free;

  assign accept   = in_valid && in_ready;
  assign in_range = ({1'b0, column} < 8'(COLUMNS)) && ({2'b00, row} < 7'(ROWS));
  assign pos_addr = ADDR_W'(ADDR_W'(row) * COLS_A) + ADDR_W'(column);
  assign res_free = !res_valid || out_ready;

  assign in_ready = (state == tcw_pkg::ST_IDLE);

  tcw_screen_ram #(
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // scroll reads run ahead of the writes; otherwise read the requested cell
  assign ram_raddr = (state == tcw_pkg::ST_SCROLL) ? src_cnt : pos_addr;

  // ---- sequencer ---------------------------------------------------------
  always_comb begin
    state_next      = state;
    wp_lin_next     = wp_lin;
    wp_row_next     = wp_row;
    wp_col_next     = wp_col;
    cursor_loc_next = cursor_loc;
    src_cnt_next    = src_cnt;
    dst_cnt_next    = dst_cnt;
    rd_pend_next    = rd_pend;
    fill_cell_next  = fill_cell;
    cell_res_next   = cell_res;
    res_valid_next  = res_valid && !out_ready;
    res_cell_next   = res_cell;
    res_index_next  = res_index;
    res_cursor_next = res_cursor;
    ram_we          = 1'b0;
    ram_waddr       = dst_cnt;
    ram_wdata       = fill_cell;

    case (state)
      tcw_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::RESET_CELL;
        if (dst_cnt == LAST_CELL) begin
          state_next = tcw_pkg::ST_IDLE;
        end else begin
          dst_cnt_next = dst_cnt + 1'b1;
        end
      end

      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          cell_res_next = '0;
          state_next    = tcw_pkg::ST_FINISH;
          // scroll setup, used by the branches that scroll
          src_cnt_next   = COLS_A;
          dst_cnt_next   = '0;
          rd_pend_next   = 1'b0;
          fill_cell_next = tcw_pkg::make_cell(tcw_pkg::SPACE_CODE, fore_colour, back_colour);
          case (operation)
            tcw_pkg::OP_PUT_CHAR: begin
              if (char_code == tcw_pkg::NEWLINE_CODE) begin
                if (wp_row == LAST_ROW) begin
                  wp_lin_next = BOTTOM_ROW;
                  wp_row_next = LAST_ROW;
                  wp_col_next = '0;
                  state_next  = tcw_pkg::ST_SCROLL;
                end else begin
                  wp_lin_next = wp_lin - ADDR_W'(wp_col) + COLS_A;
                  wp_row_next = wp_row + 1'b1;
                  wp_col_next = '0;
                end
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wp_lin;
                ram_wdata = tcw_pkg::make_cell(char_code, fore_colour, back_colour);
                if (wp_lin == LAST_CELL) begin
                  // ran off the last cell: scroll, continue on bottom row
                  wp_lin_next = BOTTOM_ROW;
                  wp_row_next = LAST_ROW;
                  wp_col_next = '0;
                  state_next  = tcw_pkg::ST_SCROLL;
                end else if (wp_col == LAST_COL) begin
                  wp_lin_next = wp_lin + 1'b1;
                  wp_row_next = wp_row + 1'b1;
                  wp_col_next = '0;
                end else begin
                  wp_lin_next = wp_lin + 1'b1;
                  wp_col_next = wp_col + 1'b1;
                end
              end
            end
            tcw_pkg::OP_WRITE_AT: begin
              if (in_range) begin
                ram_we          = 1'b1;
                ram_waddr       = pos_addr;
                ram_wdata       = tcw_pkg::make_cell(char_code, fore_colour, back_colour);
                cursor_loc_next = tcw_pkg::INDEX_W'(pos_addr);
              end
            end
            tcw_pkg::OP_READ: begin
              // read issued this cycle through pos_addr
              if (in_range) begin
                state_next = tcw_pkg::ST_READ;
              end
            end
            tcw_pkg::OP_SCROLL: begin
              // write position moves up a row, saturating at the top
              if (wp_row == '0) begin
                wp_lin_next = '0;
                wp_col_next = '0;
              end else begin
                wp_lin_next = wp_lin - COLS_A;
                wp_row_next = wp_row - 1'b1;
              end
              state_next = tcw_pkg::ST_SCROLL;
            end
            tcw_pkg::OP_CLEAR: begin
              fill_cell_next = tcw_pkg::make_cell(tcw_pkg::BLANK_CODE, fore_colour, back_colour);
              state_next     = tcw_pkg::ST_FILL;
            end
            default: begin
              state_next = tcw_pkg::ST_FINISH;
            end
          endcase
        end
      end

      tcw_pkg::ST_SCROLL: begin
        rd_pend_next = 1'b1;
        src_cnt_next = src_cnt + 1'b1;
        if (rd_pend) begin
          ram_we       = 1'b1;
          ram_wdata    = ram_rdata;
          dst_cnt_next = dst_cnt + 1'b1;
        end
        if (src_cnt == LAST_CELL) begin
          state_next = tcw_pkg::ST_SCROLL_LAST;
        end
      end

      tcw_pkg::ST_SCROLL_LAST: begin
        ram_we       = 1'b1;
        ram_wdata    = ram_rdata;
        dst_cnt_next = dst_cnt + 1'b1;
        state_next   = tcw_pkg::ST_FILL;
      end

      tcw_pkg::ST_FILL: begin
        ram_we = 1'b1;
        if (dst_cnt == LAST_CELL) begin
          state_next = tcw_pkg::ST_FINISH;
        end else begin
          dst_cnt_next = dst_cnt + 1'b1;
        end
      end

      tcw_pkg::ST_READ: begin
        cell_res_next = ram_rdata;
        state_next    = tcw_pkg::ST_FINISH;
      end

      tcw_pkg::ST_FINISH: begin
        if (res_free) begin
          res_valid_next  = 1'b1;
          res_cell_next   = cell_res;
          res_index_next  = tcw_pkg::INDEX_W'(wp_lin);
          res_cursor_next = cursor_loc;
          state_next      = tcw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // ---- registers ---------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tcw_pkg::ST_INIT;
      wp_lin     <= '0;
      wp_row     <= '0;
      wp_col     <= '0;
      cursor_loc <= '0;
      dst_cnt    <= '0;
      rd_pend    <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      wp_lin     <= wp_lin_next;
      wp_row     <= wp_row_next;
      wp_col     <= wp_col_next;
      cursor_loc <= cursor_loc_next;
      dst_cnt    <= dst_cnt_next;
      rd_pend    <= rd_pend_next;
      res_valid  <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    src_cnt    <= src_cnt_next;
    fill_cell  <= fill_cell_next;
    cell_res   <= cell_res_next;
    res_cell   <= res_cell_next;
    res_index  <= res_index_next;
    res_cursor <= res_cursor_next;
  end

  // colour registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fore_colour <= tcw_pkg::FORE_RESET;
      back_colour <= tcw_pkg::BACK_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        tcw_pkg::REG_FORE: fore_colour <= cfg_data;
        tcw_pkg::REG_BACK: back_colour <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_valid   = res_valid;
  assign cell_value  = res_cell;
  assign write_index = res_index;
  assign cursor_pos  = res_cursor;

endmodule

// ===== dv/console_result_checker.sv =====
// ----------------------------------------------------------------------------
// console_result_checker: scoreboard for the text console writer
// Keeps its own copy of the screen, write position, cursor and colours,
// predicts one result per accepted request and compares it with the result
// channel in order.
// ----------------------------------------------------------------------------
module console_result_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [0:0]             cfg_index,
  input  logic [COLOUR_W-1:0]    cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [OP_W-1:0]        operation,
  input  logic [CODE_W-1:0]      char_code,
  input  logic [COLF_W-1:0]      column,
  input  logic [ROWF_W-1:0]      row,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [CELL_W-1:0]      cell_value,
  input  logic [INDEX_W-1:0]     write_index,
  input  logic [INDEX_W-1:0]     cursor_pos,
  output int                     failures,
  output int                     pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [CELL_W-1:0]  cell_value;
    logic [INDEX_W-1:0] write_index;
    logic [INDEX_W-1:0] cursor_pos;
  } console_result_t;

  logic [CELL_W-1:0]   screen [CELLS];
  int unsigned         wpos;
  int unsigned         cur_col;
  int unsigned         cur_row;
  logic [COLOUR_W-1:0] fore;
  logic [COLOUR_W-1:0] back;
  int                  fail_total = 0;
  console_result_t     awaited_results [$];

  function automatic logic [CELL_W-1:0] coloured_cell(input logic [CODE_W-1:0] code);
    return {back, fore, code};
  endfunction

  task automatic reset_console();
    fore    = FORE_RESET;
    back    = BACK_RESET;
    wpos    = 0;
    cur_col = 0;
    cur_row = 0;
    for (int i = 0; i < CELLS; i++) screen[i] = RESET_CELL;
  endtask

  // move everything up a row, blank the bottom row, pull the write position up
  task automatic shift_screen_up();
    if (wpos < COLUMNS) wpos = 0;
    else wpos -= COLUMNS;
    for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = coloured_cell(SPACE_CODE);
  endtask

  task automatic put_character(input logic [CODE_W-1:0] code);
    int unsigned next_row;
    if (code == NEWLINE_CODE) begin
      next_row = wpos / COLUMNS + 1;
      if (next_row >= ROWS) begin
        shift_screen_up();
        wpos = CELLS - COLUMNS;
      end else begin
        wpos = next_row * COLUMNS;
      end
    end else begin
      if (wpos >= CELLS) wpos = CELLS - 1;
      screen[wpos] = coloured_cell(code);
      wpos++;
      if (wpos >= CELLS) begin
        shift_screen_up();
        wpos = CELLS - COLUMNS;
      end
    end
  endtask

  task automatic compute_console_result(input logic [OP_W-1:0] op,
                                        input logic [CODE_W-1:0] code,
                                        input int unsigned col,
                                        input int unsigned rw,
                                        output console_result_t res);
    bit                in_range;
    logic [CELL_W-1:0] read_back;
    in_range  = (col < COLUMNS) && (rw < ROWS);
    read_back = '0;
    case (op)
      OP_PUT_CHAR: put_character(code);
      OP_WRITE_AT: begin
        if (in_range) begin
          screen[rw * COLUMNS + col] = coloured_cell(code);
          cur_col = col;
          cur_row = rw;
        end
      end
      OP_READ: begin
        if (in_range) read_back = screen[rw * COLUMNS + col];
      end
      OP_SCROLL: shift_screen_up();
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = coloured_cell(BLANK_CODE);
      end
      default: ;
    endcase
    res.cell_value  = read_back;
    res.write_index = INDEX_W'(wpos);
    res.cursor_pos  = INDEX_W'(cur_row * COLUMNS + cur_col);
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_total++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    console_result_t want;
    console_result_t fresh;
    if (rst) begin
      reset_console();
      awaited_results.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_FORE: fore = cfg_data;
          REG_BACK: back = cfg_data;
          default: ;
        endcase
      end
      // a result leaving now always belongs to an earlier request
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          fail_total++;
          $display("%0t: unexpected result, expected none, actual cell 0x%0h index %0d cursor %0d",
                   $time, cell_value, write_index, cursor_pos);
        end else begin
          want = awaited_results.pop_front();
          check_field("cell_value", 32'(want.cell_value), 32'(cell_value));
          check_field("write_index", 32'(want.write_index), 32'(write_index));
          check_field("cursor_pos", 32'(want.cursor_pos), 32'(cursor_pos));
        end
      end
      if (in_valid && in_ready) begin
        compute_console_result(operation, char_code, 32'(column), 32'(row), fresh);
        awaited_results.push_back(fresh);
      end
    end
    failures      <= fail_total;
    pending_count <= awaited_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: text console writer core
// Directed requests on the field extremes and corner cases, then four phases
// of random text lines, positioned writes with read-back, reads, scrolls,
// clears and noise under different colour settings and idling patterns.
// Checking is done by console_result_checker alongside the block.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int ITEMS          = 1700;
  // operation codes the block has no use for
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_CLEAR + 3'd1;
  localparam logic [OP_W-1:0] OP_LAST_UNUSED  = '1;
  // screen edges as field values
  localparam logic [COLF_W-1:0] LAST_COL  = COLF_W'(SCREEN_COLUMNS - 1);
  localparam logic [ROWF_W-1:0] LAST_ROW  = ROWF_W'(SCREEN_ROWS - 1);
  localparam logic [COLF_W-1:0] OFF_COL   = COLF_W'(SCREEN_COLUMNS);
  localparam logic [ROWF_W-1:0] OFF_ROW   = ROWF_W'(SCREEN_ROWS);
  localparam logic [ROWF_W-1:0] ABOVE_ROW = ROWF_W'(SCREEN_ROWS - 2);

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic [0:0]           cfg_index = REG_FORE;
  logic [COLOUR_W-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      operation = OP_READ;
  logic [CODE_W-1:0]    char_code = '0;
  logic [COLF_W-1:0]    column = '0;
  logic [ROWF_W-1:0]    row = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CELL_W-1:0]    cell_value;
  logic [INDEX_W-1:0]   write_index;
  logic [INDEX_W-1:0]   cursor_pos;
  int                   failures;
  int                   pending_count;

  // idle_odds: one in idle_odds requests/cycles starts an idle burst; 0 = none
  int idle_odds = 6;
  int stall_left = 0;
  // requests that count towards the item total (noise excluded)
  int useful = 0;
  // cap on requests that can walk the whole screen (scroll, clear, newline),
  // keeps the run length bounded
  int sweeps_left = 260;
  int op_count [8];
  int unused_total = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  initial begin
    #60ms;
    $display("Verification failed");
    $finish;
  end

  text_console_writer_core #(
    .COLUMNS (SCREEN_COLUMNS),
    .ROWS    (SCREEN_ROWS)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .char_code       (char_code),
    .column          (column),
    .row             (row),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cell_value      (cell_value),
    .write_index     (write_index),
    .cursor_pos      (cursor_pos)
  );

  console_result_checker #(
    .COLUMNS (SCREEN_COLUMNS),
    .ROWS    (SCREEN_ROWS)
  ) checker_i (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .char_code       (char_code),
    .column          (column),
    .row             (row),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cell_value      (cell_value),
    .write_index     (write_index),
    .cursor_pos      (cursor_pos),
    .failures        (failures),
    .pending_count   (pending_count)
  );

  // result side back-pressure: random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // random field values, anywhere in the field or on the screen
  function automatic logic [CODE_W-1:0] any_code();
    return CODE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [COLF_W-1:0] any_column();
    return COLF_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [ROWF_W-1:0] any_row();
    return ROWF_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [COLF_W-1:0] screen_column();
    return COLF_W'($urandom_range(0, SCREEN_COLUMNS - 1));
  endfunction

  function automatic logic [ROWF_W-1:0] screen_row();
    return ROWF_W'($urandom_range(0, SCREEN_ROWS - 1));
  endfunction

  // Present one request and hold it until taken. Valid is only lowered when
  // an idle gap follows, so it is never dropped and raised in the same step.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                              input logic [COLF_W-1:0] col, input logic [ROWF_W-1:0] rw,
                              input bit counted);
    int               gap;
    logic [OP_W-1:0]  sent_op;
    sent_op = op;
    if ((op == OP_PUT_CHAR && code == NEWLINE_CODE) || op == OP_SCROLL || op == OP_CLEAR) begin
      if (sweeps_left == 0) sent_op = OP_READ;
      else sweeps_left--;
    end
    gap = 0;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= sent_op;
    char_code <= code;
    column    <= col;
    row       <= rw;
    do @(posedge clk); while (in_ready !== 1'b1);
    op_count[sent_op]++;
    if (counted) useful++;
  endtask

  // stop sending and wait until every outstanding request has its result
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // one random sequence of related requests
  task automatic send_burst();
    int                 kind;
    int                 n;
    logic [CODE_W-1:0]  code;
    logic [COLF_W-1:0]  col;
    logic [ROWF_W-1:0]  rw;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      // a line of text, sometimes long enough to wrap, usually ending in newline
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 170) : $urandom_range(0, 60);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) code = any_code();
        else code = CODE_W'($urandom_range(32, 126));
        send_request(OP_PUT_CHAR, code, any_column(), any_row(), 1'b1);
      end
      if ($urandom_range(0, 3) != 0)
        send_request(OP_PUT_CHAR, NEWLINE_CODE, any_column(), any_row(), 1'b1);
    end else if (kind < 48) begin
      // blank lines
      repeat ($urandom_range(1, 3))
        send_request(OP_PUT_CHAR, NEWLINE_CODE, any_column(), any_row(), 1'b1);
    end else if (kind < 63) begin
      // positioned write followed by read-back of the same cell
      repeat ($urandom_range(1, 6)) begin
        col  = screen_column();
        rw   = screen_row();
        code = any_code();
        send_request(OP_WRITE_AT, code, col, rw, 1'b1);
        send_request(OP_READ, any_code(), col, rw, 1'b1);
      end
    end else if (kind < 76) begin
      repeat ($urandom_range(1, 8))
        send_request(OP_READ, any_code(), screen_column(), screen_row(), 1'b1);
    end else if (kind < 82) begin
      send_request(OP_SCROLL, any_code(), any_column(), any_row(), 1'b1);
    end else if (kind < 86) begin
      send_request(OP_CLEAR, any_code(), any_column(), any_row(), 1'b1);
    end else begin
      // noise: any code, any field value, positions often off screen
      repeat ($urandom_range(1, 4))
        send_request(OP_W'($urandom_range(0, OP_LAST_UNUSED)), any_code(),
                     any_column(), any_row(), 1'b0);
    end
  endtask

  // new colours once the block is idle, then random traffic up to the target
  task automatic run_phase(input logic [COLOUR_W-1:0] fore, input logic [COLOUR_W-1:0] back,
                           input int odds, input int target);
    wait_for_results();
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_FORE;
    cfg_data     <= fore;
    @(posedge clk);
    cfg_index    <= REG_BACK;
    cfg_data     <= back;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    idle_odds = odds;
    while (useful < target) send_burst();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset colours. The first request waits out the
    // clearing pass after reset.
    send_request(OP_READ, 8'h00, 7'd0, 5'd0, 1'b1);                   // reset cell
    send_request(OP_READ, 8'h00, LAST_COL, LAST_ROW, 1'b1);
    send_request(OP_PUT_CHAR, 8'h41, 7'd0, 5'd0, 1'b1);
    send_request(OP_PUT_CHAR, 8'hFF, 7'd127, 5'd31, 1'b1);
    send_request(OP_PUT_CHAR, 8'h00, 7'd0, 5'd0, 1'b1);
    send_request(OP_PUT_CHAR, NEWLINE_CODE, 7'd0, 5'd0, 1'b1);
    // last cell, cursor at its largest value
    send_request(OP_WRITE_AT, 8'hFF, LAST_COL, LAST_ROW, 1'b1);
    send_request(OP_READ, 8'h00, LAST_COL, LAST_ROW, 1'b1);
    send_request(OP_WRITE_AT, 8'h00, 7'd0, 5'd0, 1'b1);
    // off-screen positions: write ignored, read gives zero
    send_request(OP_WRITE_AT, 8'h55, OFF_COL, 5'd0, 1'b0);
    send_request(OP_WRITE_AT, 8'h55, 7'd0, OFF_ROW, 1'b0);
    send_request(OP_WRITE_AT, 8'hAA, 7'd127, 5'd31, 1'b0);
    send_request(OP_READ, 8'h00, 7'd127, 5'd31, 1'b0);
    send_request(OP_READ, 8'h00, LAST_COL, OFF_ROW, 1'b0);
    for (int op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++)
      send_request(OP_W'(op), 8'hFF, 7'd127, 5'd31, 1'b0);
    // scroll: bottom row moves up, freed row becomes spaces
    send_request(OP_SCROLL, 8'h00, 7'd0, 5'd0, 1'b1);
    send_request(OP_READ, 8'h00, LAST_COL, ABOVE_ROW, 1'b1);
    send_request(OP_READ, 8'h00, 7'd0, LAST_ROW, 1'b1);
    // write position already on the top row: stays at zero
    send_request(OP_SCROLL, 8'h00, 7'd0, 5'd0, 1'b1);
    send_request(OP_CLEAR, 8'h00, 7'd0, 5'd0, 1'b1);
    send_request(OP_READ, 8'h00, 7'd40, 5'd12, 1'b1);
    send_request(OP_PUT_CHAR, 8'h5A, 7'd0, 5'd0, 1'b1);

    // Random phases; colour extremes included, drained in between. The last
    // phase runs with no idling on either side.
    run_phase(4'd0, 4'd15, 4, useful + (ITEMS - useful) / 4);
    run_phase(4'd9, 4'd6, 12, useful + (ITEMS - useful) / 3);
    run_phase(4'd15, 4'd15, 3, useful + (ITEMS - useful) / 2);
    run_phase(4'd0, 4'd0, 0, ITEMS);

    wait_for_results();
    // long enough for a whole-screen sweep, to catch any stray result
    repeat (SCREEN_COLUMNS * SCREEN_ROWS + 16) @(posedge clk);

    for (int op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++)
      unused_total += op_count[op];
    $display("Requests: %0d put, %0d positioned write, %0d read, %0d scroll,",
             op_count[OP_PUT_CHAR], op_count[OP_WRITE_AT], op_count[OP_READ],
             op_count[OP_SCROLL]);
    $display("  %0d clear, %0d unused; colours reset, 0/15, 9/6, 15/15, 0/0; %0d outstanding",
             op_count[OP_CLEAR], unused_total, pending_count);
    if (failures == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
